FILE: hdl/assert_macros.svh
// assertion helpers shared by the block's top, control and datapath modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/itf_pkg.sv
package itf_pkg;

    localparam int MAX_DIMENSION_DEF = 128;
    localparam int MAX_CHANNELS_DEF  = 4;

    localparam int CFG_AW = 5;

    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [2:0] REG_MIRROR_X      = 3'd3;
    localparam logic [2:0] REG_MIRROR_Y      = 3'd4;
    localparam logic [2:0] REG_SWAP_AXES     = 3'd5;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] pixel_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       not_loaded;
        logic [7:0] result_width;
        logic [7:0] result_height;
    } result_t;

    typedef struct packed {
        logic [7:0] image_width;
        logic [7:0] image_height;
        logic [2:0] channel_count;
        logic       mirror_x;
        logic       mirror_y;
        logic       swap_axes;
    } cfg_t;

    typedef struct packed {
        logic store_write;
        logic empty_read;
        logic addr_calc;
        logic ram_read;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic frame_complete;
    } stat_t;

endpackage

FILE: hdl/image_transpose_flip.sv
// write words: accepted every cycle while not busy, no result
// read words: result strobe follows address multiply, multiply by channel count and
// registered frame store read; busy holds off new words until the strobe
// read before a complete frame: result strobe in the cycle after accept
// reset and register writes while idle or settling hold busy as frame size settles
// reset clears counters and flags; frame store contents are undefined until written
`include "assert_macros.svh"

module image_transpose_flip #(
    parameter int MAX_DIMENSION = itf_pkg::MAX_DIMENSION_DEF,
    parameter int MAX_CHANNELS  = itf_pkg::MAX_CHANNELS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [itf_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  itf_pkg::item_t              item,
    output logic                        done,
    output itf_pkg::result_t            result
);

    itf_pkg::cfg_t  cfg_reg;
    itf_pkg::cmd_t  cmd;
    itf_pkg::stat_t stat;
    logic           cfg_wr;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width   <= 8'd1;
            cfg_reg.image_height  <= 8'd1;
            cfg_reg.channel_count <= 3'd4;
            cfg_reg.mirror_x      <= 1'b0;
            cfg_reg.mirror_y      <= 1'b0;
            cfg_reg.swap_axes     <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                itf_pkg::REG_IMAGE_WIDTH:   cfg_reg.image_width   <= pwdata[7:0];
                itf_pkg::REG_IMAGE_HEIGHT:  cfg_reg.image_height  <= pwdata[7:0];
                itf_pkg::REG_CHANNEL_COUNT: cfg_reg.channel_count <= pwdata[2:0];
                itf_pkg::REG_MIRROR_X:      cfg_reg.mirror_x      <= pwdata[0];
                itf_pkg::REG_MIRROR_Y:      cfg_reg.mirror_y      <= pwdata[0];
                itf_pkg::REG_SWAP_AXES:     cfg_reg.swap_axes     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            itf_pkg::REG_IMAGE_WIDTH:   prdata = {24'd0, cfg_reg.image_width};
            itf_pkg::REG_IMAGE_HEIGHT:  prdata = {24'd0, cfg_reg.image_height};
            itf_pkg::REG_CHANNEL_COUNT: prdata = {29'd0, cfg_reg.channel_count};
            itf_pkg::REG_MIRROR_X:      prdata = {31'd0, cfg_reg.mirror_x};
            itf_pkg::REG_MIRROR_Y:      prdata = {31'd0, cfg_reg.mirror_y};
            itf_pkg::REG_SWAP_AXES:     prdata = {31'd0, cfg_reg.swap_axes};
            default:                    prdata = 32'd0;
        endcase
    end

    itf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (item.mode),
        .cfg_wr (cfg_wr),
        .stat   (stat),
        .busy   (busy),
        .cmd    (cmd)
    );

    itf_dp #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .MAX_CHANNELS  (MAX_CHANNELS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .cfg    (cfg_reg),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

    `ASSERT_NXT(a_cfg_settle, clk, rst_n, psel && penable && pwrite, busy)

endmodule

FILE: hdl/itf_ram.sv
module itf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/itf_ctrl.sv
`include "assert_macros.svh"

module itf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           mode,
    input  logic           cfg_wr,
    input  itf_pkg::stat_t stat,
    output logic           busy,
    output itf_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_SETTLE1 = 3'd0;
    localparam logic [2:0] ST_SETTLE2 = 3'd1;
    localparam logic [2:0] ST_IDLE    = 3'd2;
    localparam logic [2:0] ST_RD_A    = 3'd3;
    localparam logic [2:0] ST_RD_B    = 3'd4;
    localparam logic [2:0] ST_RD_C    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_SETTLE1: state_next = ST_SETTLE2;
            ST_SETTLE2: state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (start)
                begin
                    if (mode == itf_pkg::MODE_WRITE)
                    begin
                        cmd.store_write = 1'b1;
                    end
                    else if (!stat.frame_complete)
                    begin
                        cmd.empty_read = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_RD_A;
                    end
                end
            end
            ST_RD_A:
            begin
                cmd.addr_calc = 1'b1;
                state_next    = ST_RD_B;
            end
            ST_RD_B:
            begin
                cmd.ram_read = 1'b1;
                state_next   = ST_RD_C;
            end
            ST_RD_C:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_SETTLE1;
        endcase
        // the registered size products settle after a register write while idle or settling
        if (cfg_wr && (state_reg == ST_IDLE || state_reg == ST_SETTLE1 ||
                       state_reg == ST_SETTLE2))
        begin
            state_next = ST_SETTLE1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SETTLE1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_NXT(a_wr_no_stall, clk, rst_n,
        start && !busy && mode == itf_pkg::MODE_WRITE && !cfg_wr, !busy)

endmodule

FILE: hdl/itf_dp.sv
`include "assert_macros.svh"

module itf_dp #(
    parameter int MAX_DIMENSION = itf_pkg::MAX_DIMENSION_DEF,
    parameter int MAX_CHANNELS  = itf_pkg::MAX_CHANNELS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  itf_pkg::cmd_t    cmd,
    input  itf_pkg::item_t   item,
    input  itf_pkg::cfg_t    cfg,
    output itf_pkg::stat_t   stat,
    output logic             done,
    output itf_pkg::result_t result
);

    localparam int DEPTH  = MAX_DIMENSION * MAX_DIMENSION * MAX_CHANNELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SIZE_W = $clog2(DEPTH + 1);
    localparam int WH_W   = $clog2(MAX_DIMENSION * MAX_DIMENSION + 1);
    localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
    localparam int CNT_W  = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
    localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
    localparam int CHI_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CMP_W  = (DIM_W > 8) ? DIM_W : 8;
    localparam int CHC_W  = (CH_W > 3) ? CH_W : 3;

    // clamped dimensions
    logic [CMP_W-1:0] w_raw, h_raw, ow_wide, oh_wide;
    logic [CHC_W-1:0] ch_raw;
    logic [DIM_W-1:0] w, h, ow, oh;
    logic [CH_W-1:0]  ch;

    logic [WH_W-1:0]   wh_reg;
    logic [SIZE_W-1:0] size_reg;

    logic [ADDR_W-1:0] wpos_reg;
    logic [ADDR_W:0]   wpos_inc;
    logic              complete_reg;
    logic [CNT_W-1:0]  col_reg, row_reg;
    logic [CHI_W-1:0]  chan_reg;

    logic [CNT_W-1:0]  col_c, row_c, x1, y1, sx, sy;
    logic [CHI_W-1:0]  chan_c;
    logic              last_next;
    logic              chan_wrap, col_wrap, row_wrap;

    logic [ADDR_W-1:0] pix_reg;
    logic [CHI_W-1:0]  chsel_reg;
    logic              last_reg;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rdata;

    logic              done_reg;
    itf_pkg::result_t  result_reg;

    assign w_raw  = CMP_W'(cfg.image_width);
    assign h_raw  = CMP_W'(cfg.image_height);
    assign ch_raw = CHC_W'(cfg.channel_count);

    always_comb
    begin
        if (w_raw == '0)
            w = DIM_W'(1);
        else if (w_raw > CMP_W'(MAX_DIMENSION))
            w = DIM_W'(MAX_DIMENSION);
        else
            w = DIM_W'(w_raw);

        if (h_raw == '0)
            h = DIM_W'(1);
        else if (h_raw > CMP_W'(MAX_DIMENSION))
            h = DIM_W'(MAX_DIMENSION);
        else
            h = DIM_W'(h_raw);

        if (ch_raw == '0)
            ch = CH_W'(1);
        else if (ch_raw > CHC_W'(MAX_CHANNELS))
            ch = CH_W'(MAX_CHANNELS);
        else
            ch = CH_W'(ch_raw);
    end

    assign ow      = cfg.swap_axes ? h : w;
    assign oh      = cfg.swap_axes ? w : h;
    assign ow_wide = CMP_W'(ow);
    assign oh_wide = CMP_W'(oh);

    // stale counters read as zero
    assign col_c  = (DIM_W'(col_reg) >= ow) ? '0 : col_reg;
    assign row_c  = (DIM_W'(row_reg) >= oh) ? '0 : row_reg;
    assign chan_c = (CH_W'(chan_reg) >= ch) ? '0 : chan_reg;

    assign x1 = cfg.mirror_x ? CNT_W'(ow - DIM_W'(1) - DIM_W'(col_c)) : col_c;
    assign y1 = cfg.mirror_y ? CNT_W'(oh - DIM_W'(1) - DIM_W'(row_c)) : row_c;
    assign sx = cfg.swap_axes ? y1 : x1;
    assign sy = cfg.swap_axes ? x1 : y1;

    assign last_next = (chan_c == CHI_W'(ch - CH_W'(1))) &&
                       (col_c == CNT_W'(ow - DIM_W'(1))) &&
                       (row_c == CNT_W'(oh - DIM_W'(1)));

    assign chan_wrap = (CH_W'(chan_c) + CH_W'(1)) >= ch;
    assign col_wrap  = (DIM_W'(col_c) + DIM_W'(1)) >= ow;
    assign row_wrap  = (DIM_W'(row_c) + DIM_W'(1)) >= oh;

    assign raddr    = pix_reg * ADDR_W'(ch) + ADDR_W'(chsel_reg);
    assign wpos_inc = (ADDR_W + 1)'(wpos_reg) + (ADDR_W + 1)'(1);

    // frame size, one multiply per stage
    always_ff @(posedge clk)
    begin
        wh_reg   <= WH_W'(w) * WH_W'(h);
        size_reg <= SIZE_W'(wh_reg) * SIZE_W'(ch);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.addr_calc)
        begin
            pix_reg   <= ADDR_W'(sy) * ADDR_W'(w) + ADDR_W'(sx);
            chsel_reg <= chan_c;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg     <= '0;
            complete_reg <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            chan_reg     <= '0;
        end
        else if (cmd.store_write)
        begin
            if (wpos_reg == '0)
            begin
                complete_reg <= 1'b0;
                col_reg      <= '0;
                row_reg      <= '0;
                chan_reg     <= '0;
            end
            if (wpos_inc >= (ADDR_W + 1)'(size_reg))
            begin
                wpos_reg     <= '0;
                complete_reg <= 1'b1;
            end
            else
            begin
                wpos_reg <= ADDR_W'(wpos_inc);
            end
        end
        else if (cmd.emit)
        begin
            row_reg <= row_c;
            col_reg <= col_c;
            if (chan_wrap)
            begin
                chan_reg <= '0;
                if (col_wrap)
                begin
                    col_reg <= '0;
                    row_reg <= row_wrap ? '0 : CNT_W'(DIM_W'(row_c) + DIM_W'(1));
                end
                else
                begin
                    col_reg <= CNT_W'(DIM_W'(col_c) + DIM_W'(1));
                end
            end
            else
            begin
                chan_reg <= CHI_W'(CH_W'(chan_c) + CH_W'(1));
            end
        end
    end

    itf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.store_write),
        .waddr (wpos_reg),
        .wdata (item.pixel_byte),
        .re    (cmd.ram_read),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.out_byte   <= rdata;
            result_reg.frame_end  <= last_reg;
            result_reg.not_loaded <= 1'b0;
        end
        else if (cmd.empty_read)
        begin
            result_reg.out_byte   <= 8'd0;
            result_reg.frame_end  <= 1'b0;
            result_reg.not_loaded <= 1'b1;
        end
        if (cmd.emit || cmd.empty_read)
        begin
            result_reg.result_width  <= ow_wide[7:0];
            result_reg.result_height <= oh_wide[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit | cmd.empty_read;
    end

    assign done                = done_reg;
    assign result              = result_reg;
    assign stat.frame_complete = complete_reg;

    `ASSERT_IMP(a_empty_zero, clk, rst_n,
        done_reg && result_reg.not_loaded,
        result_reg.out_byte == 8'd0 && !result_reg.frame_end)

endmodule

FILE: test/image_transpose_flip_tb.sv
module image_transpose_flip_tb;
    import itf_pkg::*;

    localparam int STORE_DEPTH = MAX_DIMENSION_DEF * MAX_DIMENSION_DEF * MAX_CHANNELS_DEF;
    localparam int ST_AW = $clog2(STORE_DEPTH);
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT = 200;
    localparam int MAX_REPORTS = 10;
    localparam logic [2:0] REG_UNMAPPED = 3'd6;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                start;
    logic                busy;
    item_t               item;
    logic                done;
    result_t             result;

    // shadow registers and frame buffer of the predictor
    logic [7:0]          cfg_width;
    logic [7:0]          cfg_height;
    logic [2:0]          cfg_channels;
    logic                cfg_mirror_x;
    logic                cfg_mirror_y;
    logic                cfg_swap;
    logic [7:0]          pixel_store [STORE_DEPTH];
    int                  wr_pos;
    int                  rd_col;
    int                  rd_row;
    int                  rd_chan;
    int                  store_fill;
    logic                frame_loaded;

    result_t             expected_bytes [$];
    int                  sender_idle_pct;
    int                  error_count;
    int                  word_count;
    int                  read_count;
    int                  empty_read_count;
    int                  frame_end_count;
    int                  reg_write_count;

    image_transpose_flip u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result)
    );

    always #4 clk = ~clk;

    function automatic int clamp_dim(input int v, input int hi);
        if (v < 1)
        begin
            return 1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic int frame_bytes();
        return clamp_dim(int'(cfg_width), MAX_DIMENSION_DEF)
            * clamp_dim(int'(cfg_height), MAX_DIMENSION_DEF)
            * clamp_dim(int'(cfg_channels), MAX_CHANNELS_DEF);
    endfunction

    // a read of a loaded frame must not reach past what was ever written
    function automatic bit read_is_safe();
        return !frame_loaded || frame_bytes() <= store_fill;
    endfunction

    function void note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endfunction

    task automatic reorient_step(input item_t w);
        int iw;
        int ih;
        int ich;
        int ow;
        int oh;
        int x1;
        int y1;
        int sx;
        int sy;
        result_t r;
        iw = clamp_dim(int'(cfg_width), MAX_DIMENSION_DEF);
        ih = clamp_dim(int'(cfg_height), MAX_DIMENSION_DEF);
        ich = clamp_dim(int'(cfg_channels), MAX_CHANNELS_DEF);
        ow = cfg_swap ? ih : iw;
        oh = cfg_swap ? iw : ih;
        if (w.mode == MODE_WRITE)
        begin
            if (wr_pos == 0)
            begin
                frame_loaded = 1'b0;
                rd_col = 0;
                rd_row = 0;
                rd_chan = 0;
            end
            if (wr_pos < STORE_DEPTH)
            begin
                pixel_store[ST_AW'(wr_pos)] = w.pixel_byte;
            end
            if (wr_pos >= store_fill)
            begin
                store_fill = wr_pos + 1;
            end
            if (wr_pos + 1 >= iw * ih * ich)
            begin
                wr_pos = 0;
                frame_loaded = 1'b1;
            end
            else
            begin
                wr_pos++;
            end
        end
        else
        begin
            r = '0;
            r.result_width = ow[7:0];
            r.result_height = oh[7:0];
            read_count++;
            if (!frame_loaded)
            begin
                r.not_loaded = 1'b1;
                empty_read_count++;
            end
            else
            begin
                // counters left outside a shrunken frame restart at zero
                if (rd_col >= ow) rd_col = 0;
                if (rd_row >= oh) rd_row = 0;
                if (rd_chan >= ich) rd_chan = 0;
                x1 = cfg_mirror_x ? ow - 1 - rd_col : rd_col;
                y1 = cfg_mirror_y ? oh - 1 - rd_row : rd_row;
                sx = cfg_swap ? y1 : x1;
                sy = cfg_swap ? x1 : y1;
                r.out_byte = pixel_store[ST_AW'((sy * iw + sx) * ich + rd_chan)];
                r.frame_end = (rd_chan == ich - 1) && (rd_col == ow - 1) && (rd_row == oh - 1);
                if (r.frame_end)
                begin
                    frame_end_count++;
                end
                rd_chan++;
                if (rd_chan >= ich)
                begin
                    rd_chan = 0;
                    rd_col++;
                    if (rd_col >= ow)
                    begin
                        rd_col = 0;
                        rd_row++;
                        if (rd_row >= oh) rd_row = 0;
                    end
                end
            end
            expected_bytes.push_back(r);
        end
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input item_t w);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        start <= 1'b1;
        item <= w;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        reorient_step(w);
        word_count++;
        @(negedge clk);
    endtask

    task automatic send_write(input logic [7:0] b);
        item_t w;
        w.mode = MODE_WRITE;
        w.pixel_byte = b;
        send_word(w);
    endtask

    task automatic send_read();
        item_t w;
        w.mode = MODE_READ;
        w.pixel_byte = 8'($urandom_range(0, 255));
        send_word(w);
    endtask

    // hold off until every result is in and the block has gone quiet
    task automatic settle();
        start <= 1'b0;
        while (expected_bytes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        while (busy)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        logic [31:0] stored;
        stored = '0;
        case (idx)
            REG_IMAGE_WIDTH:   begin cfg_width = data[7:0];    stored[7:0] = data[7:0]; end
            REG_IMAGE_HEIGHT:  begin cfg_height = data[7:0];   stored[7:0] = data[7:0]; end
            REG_CHANNEL_COUNT: begin cfg_channels = data[2:0]; stored[2:0] = data[2:0]; end
            REG_MIRROR_X:      begin cfg_mirror_x = data[0];   stored[0] = data[0]; end
            REG_MIRROR_Y:      begin cfg_mirror_y = data[0];   stored[0] = data[0]; end
            REG_SWAP_AXES:     begin cfg_swap = data[0];       stored[0] = data[0]; end
            default: ;
        endcase
        while (busy)
        begin
            @(negedge clk);
        end
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        reg_write_count++;
        if (idx > REG_SWAP_AXES)
        begin
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end
        else
        begin
            // read back straight away, psel stays high into the next setup
            penable <= 1'b0;
            pwrite <= 1'b0;
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
            begin
                @(posedge clk);
            end
            if (prdata !== stored)
            begin
                note_failure($sformatf("register %0d readback: expected %08h, got %08h",
                    idx, stored, prdata));
            end
            @(negedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            @(negedge clk);
        end
    endtask

    // unused upper bits of the bus carry noise
    task automatic write_field(input logic [2:0] idx, input int value);
        logic [31:0] data;
        data = $urandom;
        case (idx)
            REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: data[7:0] = value[7:0];
            REG_CHANNEL_COUNT:                 data[2:0] = value[2:0];
            default:                           data[0] = value[0];
        endcase
        write_reg(idx, data);
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return MAX_DIMENSION_DEF;
            2: return $urandom_range(MAX_DIMENSION_DEF + 1, 255);
            default: return MAX_DIMENSION_DEF - 1;
        endcase
    endfunction

    task automatic random_config();
        int w;
        int h;
        int ch;
        case ($urandom_range(0, 7))
            0:
            begin
                w = pick_extreme();
                h = $urandom_range(0, 2);
                ch = $urandom_range(0, 1);
            end
            1:
            begin
                h = pick_extreme();
                w = $urandom_range(0, 2);
                ch = $urandom_range(0, 1);
            end
            default:
            begin
                w = $urandom_range(1, 6);
                h = $urandom_range(1, 6);
                ch = $urandom_range(0, 7);
            end
        endcase
        settle();
        write_field(REG_IMAGE_WIDTH, w);
        write_field(REG_IMAGE_HEIGHT, h);
        write_field(REG_CHANNEL_COUNT, ch);
        write_field(REG_MIRROR_X, $urandom_range(0, 1));
        write_field(REG_MIRROR_Y, $urandom_range(0, 1));
        write_field(REG_SWAP_AXES, $urandom_range(0, 1));
    endtask

    task automatic test_read_before_load();
        send_read();
        send_write(8'h00);
        send_read();
    endtask

    // reset geometry is one pixel of four bytes
    task automatic test_frame_wrap();
        send_write(8'hFF);
        send_write(8'hA5);
        send_write(8'h5A);
        repeat (5) send_read();
    endtask

    task automatic test_reorient();
        settle();
        write_field(REG_IMAGE_WIDTH, 3);
        write_field(REG_IMAGE_HEIGHT, 2);
        write_field(REG_CHANNEL_COUNT, 0);
        write_field(REG_MIRROR_X, 1);
        write_field(REG_MIRROR_Y, 1);
        write_field(REG_SWAP_AXES, 1);
        for (int i = 1; i <= 6; i++)
        begin
            send_write(8'(i * 37));
        end
        repeat (4) send_read();
    endtask

    task automatic test_stale_counters();
        settle();
        write_field(REG_IMAGE_WIDTH, 0);
        repeat (2) send_read();
    endtask

    // a frame in progress ends early once the frame size drops below its position
    task automatic test_early_complete();
        settle();
        write_field(REG_IMAGE_WIDTH, 3);
        repeat (3) send_write(8'($urandom_range(0, 255)));
        send_read();
        settle();
        write_field(REG_IMAGE_WIDTH, 0);
        write_reg(REG_UNMAPPED, $urandom);
        send_write(8'($urandom_range(0, 255)));
        send_read();
    endtask

    task automatic test_random_frames(input int target, input int idle_pct);
        int sent;
        int n_writes;
        int n_reads;
        item_t w;
        sender_idle_pct = idle_pct;
        sent = 0;
        while (sent < target)
        begin
            random_config();
            // finish the frame in progress, or load a fresh one
            n_writes = (wr_pos < frame_bytes()) ? frame_bytes() - wr_pos : 1;
            if (n_writes > target - sent)
            begin
                n_writes = target - sent;
            end
            repeat (n_writes)
            begin
                send_write(8'($urandom_range(0, 255)));
                sent++;
            end
            n_reads = $urandom_range(1, 2 * frame_bytes() + 2);
            if (n_reads > 160)
            begin
                n_reads = 160;
            end
            if (n_reads > target - sent)
            begin
                n_reads = target - sent;
            end
            repeat (n_reads)
            begin
                w.mode = MODE_READ;
                w.pixel_byte = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 19) == 0)
                begin
                    w.mode = 1'($urandom_range(0, 1));
                end
                if (w.mode == MODE_READ && !read_is_safe())
                begin
                    w.mode = MODE_WRITE;
                end
                send_word(w);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            if (expected_bytes.size() == 0)
            begin
                note_failure($sformatf("unexpected read word: byte %02h end %0b empty %0b %0dx%0d",
                    result.out_byte, result.frame_end, result.not_loaded,
                    result.result_width, result.result_height));
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (result.out_byte !== want.out_byte || result.frame_end !== want.frame_end
                    || result.not_loaded !== want.not_loaded
                    || result.result_width !== want.result_width
                    || result.result_height !== want.result_height)
                begin
                    note_failure($sformatf({"read word mismatch: expected byte %02h end %0b ",
                        "empty %0b %0dx%0d, got byte %02h end %0b empty %0b %0dx%0d"},
                        want.out_byte, want.frame_end, want.not_loaded,
                        want.result_width, want.result_height,
                        result.out_byte, result.frame_end, result.not_loaded,
                        result.result_width, result.result_height));
                end
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("image_transpose_flip regression: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        item = '0;
        cfg_width = 8'd1;
        cfg_height = 8'd1;
        cfg_channels = 3'd4;
        cfg_mirror_x = 1'b0;
        cfg_mirror_y = 1'b0;
        cfg_swap = 1'b0;
        wr_pos = 0;
        rd_col = 0;
        rd_row = 0;
        rd_chan = 0;
        store_fill = 0;
        frame_loaded = 1'b0;
        sender_idle_pct = 10;
        error_count = 0;
        word_count = 0;
        read_count = 0;
        empty_read_count = 0;
        frame_end_count = 0;
        reg_write_count = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        settle();

        test_read_before_load();
        test_frame_wrap();
        test_reorient();
        test_stale_counters();
        test_early_complete();
        test_random_frames(210, 10);
        test_random_frames(210, 63);
        test_random_frames(210, 0);

        start <= 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && expected_bytes.size() != 0; k++)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_bytes.size() != 0)
        begin
            note_failure($sformatf("%0d read words never arrived", expected_bytes.size()));
        end

        $display("covered %0d words: %0d reads, %0d before a full frame, %0d frame ends",
            word_count, read_count, empty_read_count, frame_end_count);
        $display("%0d register accesses over clamped sizes, mirrors and transpose; %0d failures",
            reg_write_count, error_count);
        if (error_count == 0)
        begin
            $display("image_transpose_flip regression: pass");
        end
        else
        begin
            $display("image_transpose_flip regression: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/itf_pkg.sv
hdl/itf_ram.sv
hdl/itf_ctrl.sv
hdl/itf_dp.sv
hdl/image_transpose_flip.sv
test/image_transpose_flip_tb.sv
